/* src/ctht_pkg.sv */
// shared types, constants and helpers for the cache tag hit tracker
`timescale 1ns / 1ps

package ctht_pkg;

    // fixed field widths
    localparam int ADDR_FIELD_W = 20;
    localparam int LINE_FIELD_W = 6;
    localparam int COUNT_W      = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 3;

    // index field spans before wrapping onto the store
    localparam int DM_IDX_BITS_MAX = 6;
    localparam int SA_IDX_BITS_MAX = 5;
    localparam int DM_IDX_SPAN     = 64;
    localparam int SA_IDX_SPAN     = 32;

    // offset field limits
    localparam logic [CFG_DATA_W-1:0] OFF_BITS_MIN = 3'd2;
    localparam logic [CFG_DATA_W-1:0] OFF_BITS_MAX = 3'd6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DM_OFF  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DM_IDX  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SA_OFF  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SA_IDX  = 3'd4;

    // access kinds and modes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_STORE   = 1'b1;
    localparam logic MODE_DIRECT = 1'b0;
    localparam logic MODE_TWO_WAY = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] RST_DM_OFF = 3'd4;
    localparam logic [CFG_DATA_W-1:0] RST_DM_IDX = 3'd6;
    localparam logic [CFG_DATA_W-1:0] RST_SA_OFF = 3'd6;
    localparam logic [CFG_DATA_W-1:0] RST_SA_IDX = 3'd4;

    // input transaction
    typedef struct packed {
        logic                    cmd;
        logic [ADDR_FIELD_W-1:0] byte_address;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic                    hit;
        logic [LINE_FIELD_W-1:0] line_used;
        logic                    allocated;
        logic [COUNT_W-1:0]      hit_count;
        logic [COUNT_W-1:0]      reference_count;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture request, read tag ram
        logic commit;  // compare, update state, fill output register
    } ctl_cmd_t;

    // offset bits are held within their legal range
    function automatic logic [CFG_DATA_W-1:0] clamp_off(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] r;
        r = v;
        if (v < OFF_BITS_MIN) begin
            r = OFF_BITS_MIN;
        end else if (v > OFF_BITS_MAX) begin
            r = OFF_BITS_MAX;
        end
        return r;
    endfunction

    // index bits are capped at the mode's maximum
    function automatic logic [CFG_DATA_W-1:0] clamp_idx(input logic [CFG_DATA_W-1:0] v,
                                                        input logic [CFG_DATA_W-1:0] hi);
        return (v > hi) ? hi : v;
    endfunction

endpackage

/* src/cache_tag_hit_tracker_unit.sv */
// top level of the cache tag hit tracker
`timescale 1ns / 1ps

// Tag side of a small data cache, direct-mapped write-through or two-way LRU.
// An access is first accepted, then looked up: the acceptance cycle computes tag and line
// and reads both candidate tags from the tag ram, whose read data is
// registered; the lookup cycle compares, updates valid, tag and LRU state
// and loads the output register. The next access is accepted while a result
// waits in the output register; the lookup cycle holds only if the earlier
// result has still not been taken. Configuration writes are taken every cycle
// and must arrive only while no access is in flight.

module cache_tag_hit_tracker_unit #(
    parameter int LINES     = 64,
    parameter int ADDR_BITS = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctht_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ctht_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ctht_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ctht_pkg::out_item_t                m_data
);

    import ctht_pkg::*;

    ctl_cmd_t cmd;

    // sequencing
    ctht_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // lookup and state
    ctht_dp #(
        .LINES     (LINES),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

/* src/ctht_ctl.sv */
// controller state machine for the cache tag hit tracker
`timescale 1ns / 1ps

module ctht_ctl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ctht_pkg::ctl_cmd_t cmd
);

    import ctht_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a new result
    assign out_free = !out_valid_reg || m_ready;

    // command decode
    always_comb begin
        cmd.load   = (state_reg == ST_IDLE) && s_valid;
        cmd.commit = (state_reg == ST_LOOKUP) && out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    // next state
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // an accepted transaction blocks the input until it has been committed
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready while a transaction is in lookup");

    // every commit presents a result on the next cycle
    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed result not presented");

    // load and commit never overlap
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.commit))
        else $error("load and commit issued together");
`endif

endmodule

/* src/ctht_dp.sv */
// datapath: config registers, tag ram, valid and lru bits, counters, output register
`timescale 1ns / 1ps

module ctht_dp #(
    parameter int LINES     = 64,
    parameter int ADDR_BITS = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ctht_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ctht_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  ctht_pkg::in_item_t                 s_data,
    input  ctht_pkg::ctl_cmd_t                 cmd,
    output ctht_pkg::out_item_t                m_data
);

    import ctht_pkg::*;

    localparam int AW   = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
    localparam int LW   = $clog2(LINES);
    localparam int SETS = LINES / 2;
    localparam int SW   = (LW > 1) ? LW - 1 : 1;

    // configuration registers, held already clamped
    logic                  mode_reg;
    logic [CFG_DATA_W-1:0] dm_ob_reg, dm_ib_reg, sa_ob_reg, sa_ib_reg;

    // request capture
    logic [AW-1:0] tag_reg;
    logic          store_reg;
    logic [LW-1:0] line_a_reg, line_b_reg;
    logic [SW-1:0] set_reg;
    logic [AW-1:0] tag_a_reg, tag_b_reg;
    logic          valid_a_reg, valid_b_reg;

    // cache state
    logic [AW-1:0] tag_mem [LINES];
    logic          valid_reg [LINES];
    logic          recent_reg [SETS];
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0] ref_cnt_reg, ref_cnt_next;
    out_item_t     out_reg;

    // decode wires
    logic [AW-1:0]         addr;
    logic [CFG_DATA_W-1:0] ob, ib;
    logic [CFG_DATA_W:0]   shamt;
    logic [AW-1:0]         tag_in;
    logic [DM_IDX_BITS_MAX-1:0] idx_raw, idx;
    logic [LW-1:0]         dm_line;
    logic [SW-1:0]         set_in;
    logic [LW-1:0]         rd_a, rd_b;
    logic [LW-1:0]         dm_mod_tab [DM_IDX_SPAN];
    logic [SW-1:0]         sa_mod_tab [SA_IDX_SPAN];

    // compare wires
    logic          hit_a, hit_b, hit, way, alloc;
    logic [LW-1:0] line_sel;

    assign cfg_ready = 1'b1;
    assign m_data    = out_reg;

    // index wrap tables onto the line and set stores
    for (genvar g = 0; g < DM_IDX_SPAN; g++) begin : g_dm_mod
        localparam int LINE_R = g % LINES;
        assign dm_mod_tab[g] = LW'(LINE_R);
    end
    for (genvar g = 0; g < SA_IDX_SPAN; g++) begin : g_sa_mod
        localparam int SET_R = g % SETS;
        assign sa_mod_tab[g] = SW'(SET_R);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_DIRECT;
            dm_ob_reg <= RST_DM_OFF;
            dm_ib_reg <= RST_DM_IDX;
            sa_ob_reg <= RST_SA_OFF;
            sa_ib_reg <= RST_SA_IDX;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:   mode_reg  <= cfg_data[0];
                CFG_DM_OFF: dm_ob_reg <= clamp_off(cfg_data);
                CFG_DM_IDX: dm_ib_reg <= clamp_idx(cfg_data, CFG_DATA_W'(DM_IDX_BITS_MAX));
                CFG_SA_OFF: sa_ob_reg <= clamp_off(cfg_data);
                CFG_SA_IDX: sa_ib_reg <= clamp_idx(cfg_data, CFG_DATA_W'(SA_IDX_BITS_MAX));
                default: begin
                end
            endcase
        end
    end

    // address split into tag and line or set
    always_comb begin
        addr    = s_data.byte_address[AW-1:0];
        ob      = (mode_reg == MODE_TWO_WAY) ? sa_ob_reg : dm_ob_reg;
        ib      = (mode_reg == MODE_TWO_WAY) ? sa_ib_reg : dm_ib_reg;
        shamt   = {1'b0, ob} + {1'b0, ib};
        tag_in  = addr >> shamt;
        idx_raw = DM_IDX_BITS_MAX'(addr >> ob);
        idx     = idx_raw & ~({DM_IDX_BITS_MAX{1'b1}} << ib);
        dm_line = dm_mod_tab[idx];
        set_in  = sa_mod_tab[idx[SA_IDX_BITS_MAX-1:0]];
        rd_a    = (mode_reg == MODE_TWO_WAY) ? LW'({set_in, 1'b0}) : dm_line;
        rd_b    = LW'({set_in, 1'b1});
    end

    // request capture, valid bits read along with the tags
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tag_reg     <= tag_in;
            store_reg   <= (s_data.cmd == CMD_STORE);
            line_a_reg  <= rd_a;
            line_b_reg  <= rd_b;
            set_reg     <= set_in;
            valid_a_reg <= valid_reg[rd_a];
            valid_b_reg <= valid_reg[rd_b];
        end
    end

    // tag ram: two registered read ports, one write port
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tag_a_reg <= tag_mem[rd_a];
            tag_b_reg <= tag_mem[rd_b];
        end
        if (cmd.commit && alloc) begin
            tag_mem[line_sel] <= tag_reg;
        end
    end

    // tag compare and replacement choice
    always_comb begin
        hit_a = valid_a_reg && (tag_a_reg == tag_reg);
        hit_b = (mode_reg == MODE_TWO_WAY) && valid_b_reg && (tag_b_reg == tag_reg);
        hit   = hit_a || hit_b;
        if (hit_a) begin
            way = 1'b0;
        end else if (hit_b) begin
            way = 1'b1;
        end else begin
            way = recent_reg[set_reg];
        end
        if (mode_reg == MODE_TWO_WAY) begin
            alloc    = !hit;
            line_sel = way ? line_b_reg : line_a_reg;
        end else begin
            alloc    = !hit && !store_reg;
            line_sel = line_a_reg;
        end
        hit_cnt_next = hit_cnt_reg + COUNT_W'(hit);
        ref_cnt_next = ref_cnt_reg + COUNT_W'(1);
    end

    // valid bits, lru bits and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < SETS; i++) begin
                recent_reg[i] <= 1'b0;
            end
            hit_cnt_reg <= '0;
            ref_cnt_reg <= '0;
        end else if (cmd.commit) begin
            if (alloc) begin
                valid_reg[line_sel] <= 1'b1;
            end
            if (mode_reg == MODE_TWO_WAY) begin
                recent_reg[set_reg] <= ~way;
            end
            hit_cnt_reg <= hit_cnt_next;
            ref_cnt_reg <= ref_cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg.hit             <= hit;
            out_reg.line_used       <= LINE_FIELD_W'(line_sel);
            out_reg.allocated       <= alloc;
            out_reg.hit_count       <= hit_cnt_next;
            out_reg.reference_count <= ref_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    // the presented access count tracks the running counter
    a_ref_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_data.reference_count == ref_cnt_reg)
        else $error("reference count out of step");

    // a filled line is valid afterwards
    a_fill_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && alloc |=> valid_reg[$past(line_sel)])
        else $error("filled line not marked valid");

    // a hit never fills a line
    a_no_fill_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(hit && alloc))
        else $error("line filled on a hit");
`endif

endmodule
